[rtl/smt_pkg.sv]
package smt_pkg;

    // Field widths of the transfer payloads
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned MEMBER_W = 24;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_JOIN   = 2'd0,
        ACT_LEAVE  = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED    = 3'd0,
        ST_REACTIVATED = 3'd1,
        ST_ALREADY     = 3'd2,
        ST_FULL        = 3'd3,
        ST_DEACTIVATED = 3'd4,
        ST_NOT_FOUND   = 3'd5,
        ST_REMOVED     = 3'd6,
        ST_FOUND       = 3'd7
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic cmp;      // compare stored id against incoming key
        logic ins;      // open a gap at the insertion point and drop the key in
        logic rem;      // close the gap left by the matching entry
        logic set_act;  // set the flag of the matching entry
        logic clr_act;  // clear the flag of the matching entry
    } t_cell_ctl;

endpackage

[rtl/smt_if.sv]
interface smt_in_if;
    import smt_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [MEMBER_W-1:0] member_id;

    modport source (output valid, action, member_id, input ready);
    modport sink   (input valid, action, member_id, output ready);
endinterface

interface smt_out_if;
    import smt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                active;
    logic [COUNT_W-1:0]  member_count;

    modport source (output valid, status, active, member_count, input ready);
    modport sink   (input valid, status, active, member_count, output ready);
endinterface

[rtl/sorted_membership_table.sv]
// The cells register their compare flags on the input transfer; the UPD state then
// shifts/updates them and loads the result register once the result slot is free.
// No new input is taken until the compare-then-shift pass of the cell chain is done;
// a result left waiting holds the update, and the next input, until it is taken.
// Reset (synchronous, active low): member count to zero, all active flags cleared,
// no result pending; identifier storage is not cleared and no clearing pass is run.
module sorted_membership_table
    import smt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned ID_BITS     = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smt_in_if.sink      i_in,
    smt_out_if.source   o_out
);

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    t_action              r_action;
    logic [ID_BITS-1:0]   r_key;
    logic                 r_out_valid;
    t_status              r_status;
    logic                 r_active;

    logic                 w_accept;
    logic                 w_upd_go;
    logic [ID_BITS-1:0]   w_in_key;

    // Chain of cells: each holds one slot of the sorted table
    logic [ID_BITS-1:0]   w_id  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_act;
    logic [TABLE_DEPTH-1:0] w_lt;
    logic [TABLE_DEPTH-1:0] w_eq;
    t_cell_ctl            w_ctl;

    logic                 w_present;
    logic                 w_hit_act;
    logic                 w_full;

    // Bits of member_id above ID_BITS are ignored
    assign w_in_key = ID_BITS'(i_in.member_id);

    // ------------------------------------------------------------------
    // Sequencer: IDLE takes a transfer (cells compare on that edge),
    // UPD applies the shift / flag change once the result slot is free.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        w_upd_go   = 1'b0;
        case (r_state)
            S_IDLE:  i_in.ready = 1'b1;
            S_UPD:   w_upd_go   = !r_out_valid || o_out.ready;
            default: begin
                i_in.ready = 1'b0;
                w_upd_go   = 1'b0;
            end
        endcase
    end

    assign w_accept = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // Match reduction over the registered compare flags
    // ------------------------------------------------------------------
    assign w_present = |w_eq;
    assign w_hit_act = |(w_eq & w_act);
    assign w_full    = (r_count == CNT_W'(TABLE_DEPTH));

    always_comb begin
        w_ctl         = '0;
        w_ctl.cmp     = w_accept;
        if (w_upd_go) begin
            case (r_action)
                ACT_JOIN: begin
                    w_ctl.set_act = w_present;
                    w_ctl.ins     = !w_present && !w_full;
                end
                ACT_LEAVE:  w_ctl.clr_act = w_present;
                ACT_REMOVE: w_ctl.rem     = w_present;
                ACT_QUERY:  w_ctl         = w_ctl;
                default:    w_ctl         = w_ctl;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result and count for the item in UPD
    // ------------------------------------------------------------------
    t_status n_status;
    logic    n_active;

    always_comb begin
        n_status = ST_NOT_FOUND;
        n_active = 1'b0;
        n_count  = r_count;
        case (r_action)
            ACT_JOIN: begin
                if (w_present) begin
                    n_status = w_hit_act ? ST_ALREADY : ST_REACTIVATED;
                    n_active = 1'b1;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_INSERTED;
                    n_active = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            ACT_LEAVE: begin
                if (w_present) begin
                    n_status = ST_DEACTIVATED;
                end
            end
            ACT_REMOVE: begin
                if (w_present) begin
                    n_status = ST_REMOVED;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            ACT_QUERY: begin
                if (w_present) begin
                    n_status = ST_FOUND;
                    n_active = w_hit_act;
                end
            end
            default: n_status = ST_NOT_FOUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_upd_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= t_action'(i_in.action);
            r_key    <= w_in_key;
        end
        if (w_upd_go) begin
            r_status <= n_status;
            r_active <= n_active;
        end
    end

    // Count only moves on an update, which waits for the result slot,
    // so r_count matches the pending result.
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.active       = r_active;
    assign o_out.member_count = COUNT_W'(r_count);

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            logic [ID_BITS-1:0] w_left_id;
            logic               w_left_act;
            logic               w_left_lt;
            logic [ID_BITS-1:0] w_right_id;
            logic               w_right_act;

            if (gi == 0) begin : g_first
                assign w_left_id  = '0;
                assign w_left_act = 1'b0;
                assign w_left_lt  = 1'b1;
            end else begin : g_mid_l
                assign w_left_id  = w_id[gi-1];
                assign w_left_act = w_act[gi-1];
                assign w_left_lt  = w_lt[gi-1];
            end

            if (gi == TABLE_DEPTH - 1) begin : g_last
                assign w_right_id  = '0;
                assign w_right_act = 1'b0;
            end else begin : g_mid_r
                assign w_right_id  = w_id[gi+1];
                assign w_right_act = w_act[gi+1];
            end

            smt_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_cmp_key   (w_in_key),
                .i_ins_key   (r_key),
                .i_occ       (CNT_W'(gi) < r_count),
                .i_left_id   (w_left_id),
                .i_left_act  (w_left_act),
                .i_left_lt   (w_left_lt),
                .i_right_id  (w_right_id),
                .i_right_act (w_right_act),
                .o_id        (w_id[gi]),
                .o_act       (w_act[gi]),
                .o_lt        (w_lt[gi]),
                .o_eq        (w_eq[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("member count beyond table depth");

    a_single_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(w_eq))
        else $error("key matched more than one slot");

    a_insert_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd_go && w_ctl.ins) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the count");

    a_no_accept_pending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_go |=> (r_state == S_IDLE) && r_out_valid)
        else $error("update did not present a result");
`endif

endmodule

[rtl/smt_cell.sv]
module smt_cell
    import smt_pkg::*;
#(
    parameter int unsigned ID_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [ID_BITS-1:0] i_cmp_key,
    input  logic [ID_BITS-1:0] i_ins_key,
    input  logic               i_occ,
    input  logic [ID_BITS-1:0] i_left_id,
    input  logic               i_left_act,
    input  logic               i_left_lt,
    input  logic [ID_BITS-1:0] i_right_id,
    input  logic               i_right_act,
    output logic [ID_BITS-1:0] o_id,
    output logic               o_act,
    output logic               o_lt,
    output logic               o_eq
);

    logic [ID_BITS-1:0] r_id;
    logic [ID_BITS-1:0] n_id;
    logic               r_act;
    logic               n_act;
    logic               r_lt;
    logic               n_lt;
    logic               r_eq;
    logic               n_eq;

    always_comb begin
        n_id  = r_id;
        n_act = r_act;
        n_lt  = r_lt;
        n_eq  = r_eq;

        if (i_ctl.cmp) begin
            n_lt = i_occ && (r_id < i_cmp_key);
            n_eq = i_occ && (r_id == i_cmp_key);
        end

        // Cells at or above the insertion point shift up by one
        if (i_ctl.ins && !r_lt) begin
            if (i_left_lt) begin
                n_id  = i_ins_key;
                n_act = 1'b1;
            end else begin
                n_id  = i_left_id;
                n_act = i_left_act;
            end
        end

        // Cells at or above the removed entry shift down by one
        if (i_ctl.rem && !r_lt) begin
            n_id  = i_right_id;
            n_act = i_right_act;
        end

        if (i_ctl.set_act && r_eq) begin
            n_act = 1'b1;
        end
        if (i_ctl.clr_act && r_eq) begin
            n_act = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_lt  <= 1'b0;
            r_eq  <= 1'b0;
        end else begin
            r_act <= n_act;
            r_lt  <= n_lt;
            r_eq  <= n_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_id  = r_id;
    assign o_act = r_act;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule
